FILE: rtl/core/ffga_pkg.sv
// Shared types and constants for the first-fit interval gate allocator.
// Used by ffga_ctrl, ffga_datapath, the top level and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ffga_pkg;

    // Gate pool size and derived widths
    localparam int GATES  = 64;
    localparam int IDX_W  = $clog2(GATES);
    localparam int CNT_W  = $clog2(GATES + 1);

    // Fixed field widths
    localparam int ID_W   = 16;
    localparam int TIME_W = 11;
    localparam int FREE_W = 12;
    localparam int USE_W  = 8;
    localparam int GATE_W = 7;
    localparam int LIM_W  = 7;
    localparam int MEM_W  = USE_W + FREE_W;

    // Stream packing
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    // Configuration
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = TIME_W;
    localparam logic [CFG_ADDR_W-1:0] REG_TURNAROUND = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_GATE_LIMIT = 1'b1;
    localparam logic [TIME_W-1:0]     TURN_RESET     = 11'd20;
    localparam logic [LIM_W-1:0]      LIMIT_RESET    = 7'd50;
    localparam logic [USE_W-1:0]      USE_MAX        = 8'd255;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic accept;     // latch a new request
        logic issue;      // read the next open gate
        logic take_hit;   // compared gate is free: pick it
        logic take_miss;  // scan exhausted: open a gate or give up
        logic load_out;   // commit gate state and load the result
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic scan_end;   // every open gate has been read
        logic cmp_valid;  // a read gate is waiting to be compared
        logic cmp_hit;    // that gate is free at the arrival time
        logic out_free;   // result register can take a new result
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/first_fit_interval_gate_allocator_unit.sv
// Top level of the first-fit interval gate allocator.
// Depends on ffga_pkg, ffga_ctrl and ffga_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Requests enter on the s_axis channel: one interval per transfer, with
//   tuser set on the first interval of a run to release every gate first.
//   Results leave on the m_axis channel, one per request, in order.
//   turnaround_time (index 0) and gate_limit (index 1) are written through
//   cfg_wen/cfg_addr/cfg_data while the block is idle.
// Scan and request flow
//   The scan reads one open gate per cycle from the gate memory, whose
//   read data is registered, so the gate memory read port sets the rate.
//   A request scans the open gates in order and takes the first one that is
//   free by its arrival; with no hit it opens a new gate while under the
//   gate limit. One request is in work at a time; the next is taken the
//   cycle after the result is loaded.
// Reset
//   Reset releases all gates (open count zero) and loads turnaround 20 and
//   gate limit 50. Gate memory needs no clearing: only gates below the
//   open count are ever read, and a newly opened gate is fully rewritten.
// Back-pressure
//   The result register holds while m_axis_tready is low; a finished
//   request waits in its commit step until the register frees up.
module first_fit_interval_gate_allocator_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // request stream
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [15:0] item_id, [26:16] arrival_time, [37:27] departure_time, [39:38] zero
    input  wire logic [ffga_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // [0] first_of_run
    input  wire logic                                  s_axis_tuser,
    // result stream
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [15:0] item_id_out, [16] assigned, [23:17] gate_number,
    // [30:24] gates_open, [38:31] gate_use_count, [39] zero
    output logic [ffga_pkg::OUT_DATA_W-1:0]            m_axis_tdata,
    // configuration
    input  wire logic                                  cfg_wen,
    input  wire logic [ffga_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [ffga_pkg::CFG_DATA_W-1:0]       cfg_data
);

    ffga_pkg::ctrl_cmd_t  cmd;
    ffga_pkg::dp_status_t status;

    logic [ffga_pkg::ID_W-1:0]   item_id_out;
    logic                        assigned;
    logic [ffga_pkg::GATE_W-1:0] gate_number;
    logic [ffga_pkg::GATE_W-1:0] gates_open;
    logic [ffga_pkg::USE_W-1:0]  gate_use_count;

    ffga_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ffga_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .first_of_run   (s_axis_tuser),
        .item_id        (s_axis_tdata[15:0]),
        .arrival_time   (s_axis_tdata[26:16]),
        .departure_time (s_axis_tdata[37:27]),
        .cfg_wen        (cfg_wen),
        .cfg_addr       (cfg_addr),
        .cfg_data       (cfg_data),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .item_id_out    (item_id_out),
        .assigned       (assigned),
        .gate_number    (gate_number),
        .gates_open     (gates_open),
        .gate_use_count (gate_use_count)
    );

    // Pack the result fields, lowest field first
    assign m_axis_tdata = {1'b0, gate_use_count, gates_open, gate_number, assigned,
                           item_id_out};

endmodule

`default_nettype wire

FILE: rtl/core/ffga_ctrl.sv
// Controller state machine for the gate allocator.
// Depends on ffga_pkg; drives ffga_datapath through ctrl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module ffga_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ffga_pkg::dp_status_t status,
    output ffga_pkg::ctrl_cmd_t     cmd
);

    ffga_pkg::ctrl_state_t state_reg;
    ffga_pkg::ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffga_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffga_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ffga_pkg::ST_SCAN;
                end
            end
            ffga_pkg::ST_SCAN:
            begin
                if (status.cmp_hit || (status.scan_end && !status.cmp_valid))
                begin
                    state_next = ffga_pkg::ST_COMMIT;
                end
            end
            ffga_pkg::ST_COMMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ffga_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffga_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ffga_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ffga_pkg::ST_SCAN:
            begin
                if (status.cmp_hit)
                begin
                    cmd.take_hit = 1'b1;
                end
                else if (status.scan_end && !status.cmp_valid)
                begin
                    cmd.take_miss = 1'b1;
                end
                else
                begin
                    cmd.issue = !status.scan_end;
                end
            end
            ffga_pkg::ST_COMMIT:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // A hit is taken only on a compared gate that is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_hit |-> (status.cmp_valid && status.cmp_hit))
        else $error("ffga_ctrl: hit taken without a valid compare");

    // A result is loaded only when the result register has room
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("ffga_ctrl: result loaded over a pending result");

    // An accepted request always starts a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == ffga_pkg::ST_SCAN))
        else $error("ffga_ctrl: accepted request did not start a scan");

endmodule

`default_nettype wire

FILE: rtl/core/ffga_datapath.sv
// Datapath for the gate allocator: request latch, gate memory, scan
// compare, configuration registers and result register. Depends on ffga_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffga_datapath (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ffga_pkg::ctrl_cmd_t             cmd,
    output ffga_pkg::dp_status_t                 status,
    // request fields
    input  wire logic                            first_of_run,
    input  wire logic [ffga_pkg::ID_W-1:0]       item_id,
    input  wire logic [ffga_pkg::TIME_W-1:0]     arrival_time,
    input  wire logic [ffga_pkg::TIME_W-1:0]     departure_time,
    // configuration
    input  wire logic                            cfg_wen,
    input  wire logic [ffga_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [ffga_pkg::CFG_DATA_W-1:0] cfg_data,
    // result
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic [ffga_pkg::ID_W-1:0]            item_id_out,
    output logic                                 assigned,
    output logic [ffga_pkg::GATE_W-1:0]          gate_number,
    output logic [ffga_pkg::GATE_W-1:0]          gates_open,
    output logic [ffga_pkg::USE_W-1:0]           gate_use_count
);

    // Configuration registers
    logic [ffga_pkg::TIME_W-1:0] turn_reg;
    logic [ffga_pkg::LIM_W-1:0]  limit_reg;

    // Control state
    logic [ffga_pkg::CNT_W-1:0]  open_reg;
    logic [ffga_pkg::CNT_W-1:0]  open_next;
    logic [ffga_pkg::CNT_W-1:0]  idx_reg;
    logic                        cmp_valid_reg;
    logic                        out_valid_reg;

    // Request and decision payload
    logic [ffga_pkg::ID_W-1:0]   id_reg;
    logic [ffga_pkg::TIME_W-1:0] arr_reg;
    logic [ffga_pkg::TIME_W-1:0] dep_reg;
    logic [ffga_pkg::IDX_W-1:0]  cmp_idx_reg;
    logic [ffga_pkg::MEM_W-1:0]  rd_data_reg;
    logic [ffga_pkg::IDX_W-1:0]  pick_reg;
    logic [ffga_pkg::IDX_W-1:0]  pick_next;
    logic                        hit_reg;
    logic                        hit_next;
    logic [ffga_pkg::USE_W-1:0]  uses_reg;
    logic [ffga_pkg::USE_W-1:0]  uses_next;

    // Result payload
    logic [ffga_pkg::ID_W-1:0]   out_id_reg;
    logic                        out_hit_reg;
    logic [ffga_pkg::GATE_W-1:0] out_gate_reg;
    logic [ffga_pkg::GATE_W-1:0] out_open_reg;
    logic [ffga_pkg::USE_W-1:0]  out_uses_reg;

    // Gate memory: {use count, free-at}; entries at or above open_reg are stale
    logic [ffga_pkg::MEM_W-1:0]  gate_mem [ffga_pkg::GATES];

    logic [ffga_pkg::FREE_W-1:0] rd_free;
    logic [ffga_pkg::USE_W-1:0]  rd_uses;
    logic [ffga_pkg::FREE_W-1:0] free_new;
    logic                        open_ok;

    assign rd_free  = rd_data_reg[ffga_pkg::FREE_W-1:0];
    assign rd_uses  = rd_data_reg[ffga_pkg::MEM_W-1:ffga_pkg::FREE_W];
    assign free_new = ffga_pkg::FREE_W'(dep_reg) + ffga_pkg::FREE_W'(turn_reg);
    assign open_ok  = (32'(open_reg) < 32'(limit_reg)) && (32'(open_reg) < ffga_pkg::GATES);

    // Status back to the controller
    always_comb
    begin
        status.scan_end  = (idx_reg >= open_reg);
        status.cmp_valid = cmp_valid_reg;
        status.cmp_hit   = cmp_valid_reg && (rd_free <= ffga_pkg::FREE_W'(arr_reg));
        status.out_free  = !out_valid_reg || out_ready;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_reg  <= ffga_pkg::TURN_RESET;
            limit_reg <= ffga_pkg::LIMIT_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_addr)
                ffga_pkg::REG_TURNAROUND: turn_reg  <= cfg_data;
                ffga_pkg::REG_GATE_LIMIT: limit_reg <= cfg_data[ffga_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Decide the gate for a hit or a miss; release all gates on the first request of a run
    always_comb
    begin
        pick_next = pick_reg;
        hit_next  = hit_reg;
        uses_next = uses_reg;
        open_next = open_reg;
        if (cmd.accept && first_of_run)
        begin
            open_next = '0;
        end
        else if (cmd.take_hit)
        begin
            pick_next = cmp_idx_reg;
            hit_next  = 1'b1;
            uses_next = (rd_uses == ffga_pkg::USE_MAX) ? rd_uses : rd_uses + 1'b1;
        end
        else if (cmd.take_miss)
        begin
            pick_next = open_reg[ffga_pkg::IDX_W-1:0];
            hit_next  = open_ok;
            uses_next = ffga_pkg::USE_W'(1);
            if (open_ok)
            begin
                open_next = open_reg + 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg      <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            open_reg      <= open_next;
            cmp_valid_reg <= cmd.issue;
            if (cmd.accept)
            begin
                idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request and decision payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            id_reg  <= item_id;
            arr_reg <= arrival_time;
            dep_reg <= departure_time;
        end
        if (cmd.issue)
        begin
            cmp_idx_reg <= idx_reg[ffga_pkg::IDX_W-1:0];
        end
        pick_reg <= pick_next;
        hit_reg  <= hit_next;
        uses_reg <= uses_next;
    end

    // Gate memory read port
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_data_reg <= gate_mem[idx_reg[ffga_pkg::IDX_W-1:0]];
        end
    end

    // Gate memory write port: commit the chosen gate
    always_ff @(posedge clk)
    begin
        if (cmd.load_out && hit_reg)
        begin
            gate_mem[pick_reg] <= {uses_reg, free_new};
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_id_reg   <= id_reg;
            out_hit_reg  <= hit_reg;
            out_gate_reg <= hit_reg ? ffga_pkg::GATE_W'(pick_reg) + 1'b1 : '0;
            out_open_reg <= ffga_pkg::GATE_W'(open_reg);
            out_uses_reg <= hit_reg ? uses_reg : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign item_id_out    = out_id_reg;
    assign assigned       = out_hit_reg;
    assign gate_number    = out_gate_reg;
    assign gates_open     = out_open_reg;
    assign gate_use_count = out_uses_reg;

    // Open gate count never exceeds the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(open_reg) <= ffga_pkg::GATES)
        else $error("ffga_datapath: open gate count beyond pool size");

    // Reads stay below the open gate count
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (idx_reg < open_reg))
        else $error("ffga_datapath: read beyond the open gates");

    // A stalled result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("ffga_datapath: stalled result dropped");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for first_fit_interval_gate_allocator_unit.
// Drives intervals on the request stream, predicts every placement and
// checks each result; depends on ffga_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module testbench;

    import ffga_pkg::*;

    localparam int LAST_MINUTE = 1439;
    localparam int STALL_LIMIT = 1000;
    localparam int IDLE_PCT    = 36;

    // One placement as it leaves the block, in tdata order from the bottom up
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic              assigned;
        logic [GATE_W-1:0] gate;
        logic [GATE_W-1:0] opened;
        logic [USE_W-1:0]  uses;
    } placement_t;

    typedef enum logic {
        ROW_REQUEST,
        ROW_CONFIG
    } row_kind_t;

    // Directed row: a config write (turn, limit) or one request
    typedef struct packed {
        row_kind_t         kind;
        logic [TIME_W-1:0] turn;
        logic [LIM_W-1:0]  limit;
        logic              first;
        logic [TIME_W-1:0] arr;
        logic [TIME_W-1:0] dep;
        logic              typed;
        placement_t        want;
    } stim_row_t;

    // Directed requests; rows with typed set carry the placement read off by hand
    localparam stim_row_t DIRECTED_ROWS [16] = '{
        // reset setting: turnaround 20, limit 50
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b1, 11'd0, 11'd0, 1'b1,
          '{16'h0000, 1'b1, 7'd1, 7'd1, 8'd1}},
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b0, 11'd0, 11'd1439, 1'b1,
          '{16'hffff, 1'b1, 7'd2, 7'd2, 8'd1}},
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b0, 11'd20, 11'd30, 1'b1,
          '{16'h1234, 1'b1, 7'd1, 7'd2, 8'd2}},
        // departure before arrival
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b0, 11'd1439, 11'd0, 1'b1,
          '{16'h8000, 1'b1, 7'd1, 7'd2, 8'd3}},
        // arrival out of order
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b0, 11'd10, 11'd10, 1'b1,
          '{16'h7fff, 1'b1, 7'd3, 7'd3, 8'd1}},
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b0, 11'd25, 11'd100, 1'b0,
          '{16'h00ff, 1'b0, 7'd0, 7'd0, 8'd0}},
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b1, 11'd1439, 11'd1439, 1'b1,
          '{16'habcd, 1'b1, 7'd1, 7'd1, 8'd1}},
        // single gate, no turnaround: second overlap goes unassigned
        '{ROW_CONFIG, 11'd0, 7'd1, 1'b0, 11'd0, 11'd0, 1'b0, '0},
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b1, 11'd100, 11'd200, 1'b1,
          '{16'h0001, 1'b1, 7'd1, 7'd1, 8'd1}},
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b0, 11'd150, 11'd160, 1'b1,
          '{16'h0002, 1'b0, 7'd0, 7'd1, 8'd0}},
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b0, 11'd200, 11'd200, 1'b1,
          '{16'h0003, 1'b1, 7'd1, 7'd1, 8'd2}},
        // longest turnaround: free-at runs past the last minute
        '{ROW_CONFIG, 11'd1439, 7'd64, 1'b0, 11'd0, 11'd0, 1'b0, '0},
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b1, 11'd0, 11'd1439, 1'b1,
          '{16'h5555, 1'b1, 7'd1, 7'd1, 8'd1}},
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b0, 11'd1439, 11'd1439, 1'b1,
          '{16'haaaa, 1'b1, 7'd2, 7'd2, 8'd1}},
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b0, 11'd1439, 11'd0, 1'b0,
          '{16'h0f0f, 1'b0, 7'd0, 7'd0, 8'd0}},
        '{ROW_REQUEST, 11'd0, 7'd0, 1'b1, 11'd0, 11'd0, 1'b1,
          '{16'hf0f0, 1'b1, 7'd1, 7'd1, 8'd1}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_wen = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Gate pool model
    logic [FREE_W-1:0] free_at_m [GATES] = '{default: '0};
    logic [USE_W-1:0]  uses_m [GATES] = '{default: '0};
    logic [GATE_W-1:0] open_m = '0;
    logic [TIME_W-1:0] turnaround_m = TURN_RESET;
    logic [LIM_W-1:0]  gate_limit_m = LIMIT_RESET;

    placement_t placement_q [$];

    // Handshakes and result data sampled mid-cycle
    bit                    request_taken;
    bit                    result_taken;
    logic [OUT_DATA_W-1:0] result_word;

    bit steady = 1'b0;
    int mismatches = 0;
    int stall_cycles = 0;

    first_fit_interval_gate_allocator_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Place one interval on the gate model and return the placement it yields
    function automatic placement_t place_interval(input logic first,
            input logic [ID_W-1:0] id, input logic [TIME_W-1:0] arr,
            input logic [TIME_W-1:0] dep);
        placement_t r;
        int pick;
        int reach;
        bit hit;
        pick = 0;
        hit = 1'b0;
        reach = (gate_limit_m < GATES) ? int'(gate_limit_m) : GATES;
        if (first)
        begin
            for (int g = 0; g < GATES; g++)
            begin
                free_at_m[g] = '0;
                uses_m[g] = '0;
            end
            open_m = '0;
        end
        // first open gate that is free by the arrival
        for (int g = 0; g < GATES; g++)
        begin
            if (!hit && g < open_m && free_at_m[g] <= FREE_W'(arr))
            begin
                pick = g;
                hit = 1'b1;
            end
        end
        // else open a new gate while under the limit
        if (!hit && open_m < reach)
        begin
            pick = open_m;
            open_m = open_m + 1'b1;
            hit = 1'b1;
        end
        r.id = id;
        r.assigned = hit;
        r.opened = open_m;
        if (hit)
        begin
            free_at_m[pick] = FREE_W'(dep) + FREE_W'(turnaround_m);
            if (uses_m[pick] != USE_MAX)
                uses_m[pick] = uses_m[pick] + 1'b1;
            r.gate = GATE_W'(pick + 1);
            r.uses = uses_m[pick];
        end
        else
        begin
            r.gate = '0;
            r.uses = '0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Present one request, hold it until taken, then log its placement
    task automatic send_interval(input logic first, input logic [ID_W-1:0] id,
            input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] dep,
            input bit typed, input placement_t typed_want);
        placement_t predicted;
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, dep, arr, id};
        s_axis_tuser  <= first;
        @(posedge clk);
        while (!request_taken)
            @(posedge clk);
        predicted = place_interval(first, id, arr, dep);
        placement_q.push_back(typed ? typed_want : predicted);
    endtask

    // Drain all results, then write both registers
    task automatic write_gate_config(input logic [TIME_W-1:0] turn,
            input logic [LIM_W-1:0] limit);
        s_axis_tvalid <= 1'b0;
        while (placement_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_wen  <= 1'b1;
        cfg_addr <= REG_TURNAROUND;
        cfg_data <= turn;
        @(posedge clk);
        cfg_addr <= REG_GATE_LIMIT;
        cfg_data <= CFG_DATA_W'(limit);
        @(posedge clk);
        cfg_wen <= 1'b0;
        turnaround_m = turn;
        gate_limit_m = limit;
    endtask

    // Sample both handshakes away from the active edge
    always @(negedge clk)
    begin
        request_taken = rst_n && s_axis_tvalid && s_axis_tready;
        result_taken  = rst_n && m_axis_tvalid && m_axis_tready;
        result_word   = m_axis_tdata;
    end

    // Result side back-pressure
    always @(posedge clk)
    begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Check each result against the oldest placement; watch for a hang
    always @(posedge clk)
    begin : result_check
        placement_t want;
        placement_t got;
        if (result_taken)
        begin
            got = {result_word[15:0], result_word[16], result_word[23:17],
                   result_word[30:24], result_word[38:31]};
            if (placement_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no request pending, expected none, actual %h",
                         $time, got);
            end
            else
            begin
                want = placement_q.pop_front();
                check_field("item_id_out", want.id, got.id);
                check_field("assigned", want.assigned, got.assigned);
                check_field("gate_number", want.gate, got.gate);
                check_field("gates_open", want.opened, got.opened);
                check_field("gate_use_count", want.uses, got.uses);
            end
        end
        if (request_taken || result_taken || cfg_wen)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        stim_row_t row;
        int arr_i;
        int dep_i;
        int use_arr;
        int run_len;
        int left;
        int noise;
        logic [TIME_W-1:0] turn;
        logic [LIM_W-1:0]  limit;
        logic first;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (DIRECTED_ROWS[i])
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_CONFIG)
                write_gate_config(row.turn, row.limit);
            else
                send_interval(row.first, row.want.id, row.arr, row.dep, row.typed, row.want);
        end

        // One gate takes back-to-back zero-length stays until its count saturates
        write_gate_config(11'd0, 7'd2);
        arr_i = 0;
        for (int j = 0; j < 300; j++)
        begin
            arr_i = arr_i + $urandom_range(0, 4);
            if (arr_i > LAST_MINUTE)
                arr_i = LAST_MINUTE;
            send_interval(j == 0, ID_W'($urandom), TIME_W'(arr_i), TIME_W'(arr_i), 1'b0, '0);
        end

        // Long overlapping stays open the whole pool, then the rest go unassigned
        write_gate_config(11'd1439, 7'd64);
        for (int j = 0; j < 80; j++)
            send_interval(j == 0, ID_W'($urandom), TIME_W'(j / 8),
                          TIME_W'($urandom_range(1000, LAST_MINUTE)), 1'b0, '0);

        // Random phases: runs of sorted intervals with some noise mixed in
        for (int p = 0; p < 8; p++)
        begin
            case ($urandom_range(0, 3))
                0: turn = 11'd0;
                1: turn = 11'd1439;
                default: turn = TIME_W'($urandom_range(0, LAST_MINUTE));
            endcase
            case ($urandom_range(0, 3))
                0: limit = 7'd1;
                1: limit = 7'd64;
                default: limit = LIM_W'($urandom_range(1, 64));
            endcase
            write_gate_config(turn, limit);
            steady = (p == 3 || p == 4);
            left = 110;
            while (left > 0)
            begin
                run_len = $urandom_range(1, 40);
                if (run_len > left)
                    run_len = left;
                left = left - run_len;
                arr_i = $urandom_range(0, 1000);
                for (int j = 0; j < run_len; j++)
                begin
                    arr_i = arr_i + $urandom_range(0, 40);
                    if (arr_i > LAST_MINUTE)
                        arr_i = LAST_MINUTE;
                    noise = $urandom_range(0, 99);
                    use_arr = (noise < 6) ? $urandom_range(0, LAST_MINUTE) : arr_i;
                    dep_i = use_arr + $urandom_range(0, 240);
                    if (dep_i > LAST_MINUTE)
                        dep_i = LAST_MINUTE;
                    if (noise >= 6 && noise < 14)
                        dep_i = $urandom_range(0, LAST_MINUTE);
                    first = (j == 0) || ($urandom_range(0, 99) < 2);
                    send_interval(first, ID_W'($urandom), TIME_W'(use_arr), TIME_W'(dep_i),
                                  1'b0, '0);
                end
            end
        end
        steady = 1'b0;

        // Drain and settle
        s_axis_tvalid <= 1'b0;
        while (placement_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
